/* src/pcc_pkg.sv */
package pcc_pkg;

	localparam int VAL_W = 9;
	localparam int RES_W = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TEST,
		ST_DIV,
		ST_FRD,
		ST_FWR,
		ST_MRD,
		ST_MLD,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef enum logic {
		OP_PERM = 1'b0,
		OP_COMB = 1'b1
	} op_t;

endpackage

/* src/pcc_ram.sv */
module pcc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/pcc_div.sv */
module pcc_div
	import pcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic             done,
	output logic [VAL_W-1:0] quot,
	output logic [VAL_W-1:0] rem
);

	localparam int CW = $clog2(VAL_W + 1);

	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] quot_q;
	logic [VAL_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VAL_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quot_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];
			quot_q <= {quot_q[VAL_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* src/permutation_combination_counter.sv */
// Steps: accept, a clearing pass over all MAX_N+1 table entries, then per factor (k of them, 2k
// for a combination) trial divisions, each a test step and a shared bit-serial divider run,
// and a read and a write per table update; then a read, a load and a multiply step per table
// entry from 2 to MAX_N plus a multiply per prime factor, and a load of the output register.
// Items are taken one at a time; one with k > n or n > MAX_N goes straight to the output load.
// Reset clears the control state; the exponent table is cleared at the start of each item with k <= n <= MAX_N.
module permutation_combination_counter
	import pcc_pkg::*;
#(
	parameter int MAX_N = 511
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [VAL_W-1:0] n,
	input  logic [VAL_W-1:0] k,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RES_W-1:0] result,
	output logic             status
);

	localparam int DEPTH = MAX_N + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(DEPTH) + 1;

	state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      pm_q;
	logic [VAL_W-1:0]   v_q, hi_q, k_q, rest_q, p_q, fac_q;
	logic               sub_q;
	logic               comb_q;
	logic [EW-1:0]      e_q;
	logic [RES_W-1:0]   prod_q;
	logic [RES_W-1:0]   res_q;
	logic               err_q;
	logic               ovalid_q;
	logic [RES_W-1:0]   oresult_q;
	logic               ostatus_q;

	logic               accept, bad, out_free;
	logic [2*VAL_W-1:0] psq;
	logic [VAL_W-1:0]   lo;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [EW-1:0]      wdata, rdata;

	logic               div_start;
	logic               div_done;
	logic [VAL_W-1:0]   dquot, drem;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign bad      = (k > n) || (32'(n) > MAX_N);
	assign out_free = !ovalid_q || !out_stall;
	assign psq      = p_q * p_q;
	assign lo       = n - k + 1'b1;

	pcc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	pcc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rest_q),
		.divisor (p_q),
		.done    (div_done),
		.quot    (dquot),
		.rem     (drem)
	);

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = AW'(fac_q);
		wdata     = sub_q ? rdata - 1'b1 : rdata + 1'b1;
		raddr     = AW'(fac_q);
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = bad ? ST_DONE : ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == AW'(MAX_N)) begin
					state_d = (k_q == '0) ? ST_MRD : ST_TEST;
				end
			end
			ST_TEST: begin
				if (rest_q == VAL_W'(1)) begin
					if (v_q == hi_q && (sub_q || !comb_q)) begin
						state_d = ST_MRD;
					end
				end else if (psq > (2*VAL_W)'(rest_q)) begin
					state_d = ST_FRD;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (drem == '0) ? ST_FRD : ST_TEST;
				end
			end
			ST_FRD: state_d = ST_FWR;
			ST_FWR: begin
				we      = 1'b1;
				state_d = ST_TEST;
			end
			ST_MRD: begin
				raddr   = pm_q;
				state_d = ST_MLD;
			end
			ST_MLD: state_d = ST_MUL;
			ST_MUL: begin
				if (e_q == '0) begin
					state_d = (pm_q == AW'(MAX_N)) ? ST_DONE : ST_MRD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				clr_q  <= '0;
				comb_q <= operation == OP_COMB;
				sub_q  <= 1'b0;
				k_q    <= k;
				v_q    <= lo;
				rest_q <= lo;
				hi_q   <= n;
				p_q    <= VAL_W'(2);
				pm_q   <= AW'(2);
				prod_q <= RES_W'(1);
				res_q  <= '0;
				err_q  <= 1'b1;
			end
			ST_CLEAR: clr_q <= clr_q + 1'b1;
			ST_TEST: begin
				if (rest_q == VAL_W'(1)) begin
					p_q <= VAL_W'(2);
					if (v_q != hi_q) begin
						v_q    <= v_q + 1'b1;
						rest_q <= v_q + 1'b1;
					end else if (!sub_q) begin
						sub_q  <= 1'b1;
						v_q    <= VAL_W'(1);
						rest_q <= VAL_W'(1);
						hi_q   <= k_q;
					end
				end else if (psq > (2*VAL_W)'(rest_q)) begin
					fac_q  <= rest_q;
					rest_q <= VAL_W'(1);
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (drem == '0) begin
						rest_q <= dquot;
						fac_q  <= p_q;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
			end
			ST_MLD: e_q <= rdata;
			ST_MUL: begin
				if (e_q == '0) begin
					pm_q  <= pm_q + 1'b1;
					res_q <= prod_q;
					err_q <= 1'b0;
				end else begin
					prod_q <= RES_W'(prod_q * pm_q);
					e_q    <= e_q - 1'b1;
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			oresult_q <= res_q;
			ostatus_q <= err_q;
		end
	end

	assign out_valid = ovalid_q;
	assign result    = oresult_q;
	assign status    = ostatus_q;

endmodule

/* tb/sv/permutation_combination_counter_checker.sv */
`timescale 1ns / 1ps

module permutation_combination_counter_checker
	import pcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             operation,
	input  logic [VAL_W-1:0] n,
	input  logic [VAL_W-1:0] k,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [RES_W-1:0] result,
	input  logic             status,
	output int               fails,
	output int               pending
);

	localparam int TABLE_TOP = 511;

	typedef struct {
		logic [RES_W-1:0] count;
		logic             err;
	} count_t;

	count_t awaited_counts[$];

	function automatic void tally_factors(ref int expo[TABLE_TOP+1], input int lo, input int hi,
			input int sgn);
		int v;
		int rest;
		int p;
		for (v = lo; v <= hi && v != 0; v++) begin
			rest = v;
			p = 2;
			while (rest > 1) begin
				while (rest % p == 0) begin
					rest = rest / p;
					expo[p] += sgn;
				end
				p++;
			end
		end
	endfunction

	function automatic count_t count_ways(op_t op, int nn, int kk);
		int expo[TABLE_TOP+1];
		count_t c;
		logic [RES_W-1:0] acc;
		logic [RES_W-1:0] b;
		int e;
		c.count = '0;
		c.err = 1'b1;
		if (kk > nn || nn > TABLE_TOP)
			return c;
		foreach (expo[i])
			expo[i] = 0;
		if (kk > 0)
			tally_factors(expo, nn - kk + 1, nn, 1);
		if (op == OP_COMB && kk > 0)
			tally_factors(expo, 1, kk, -1);
		c.count = 64'd1;
		c.err = 1'b0;
		for (int p = 2; p <= TABLE_TOP; p++) begin
			if (expo[p] > 0) begin
				acc = 64'd1;
				b = RES_W'(p);
				e = expo[p];
				while (e != 0) begin
					if (e[0])
						acc = acc * b;
					b = b * b;
					e = e >> 1;
				end
				c.count = c.count * acc;
			end
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		count_t want;
		if (!arst_n) begin
			fails <= 0;
			pending <= 0;
			awaited_counts.delete();
		end else begin
			if (in_valid && !in_stall)
				awaited_counts.push_back(count_ways(op_t'(operation), int'(n), int'(k)));
			if (out_valid && !out_stall) begin
				if (awaited_counts.size() == 0) begin
					if (fails < 10)
						$display("unexpected result item: result=%0d status=%0d", result, status);
					fails <= fails + 1;
				end else begin
					want = awaited_counts.pop_front();
					if (result !== want.count || status !== want.err) begin
						if (fails < 10)
							$display("mismatch: result exp %0d got %0d, status exp %0d got %0d",
								want.count, result, want.err, status);
						fails <= fails + 1;
					end
				end
			end
			pending <= awaited_counts.size();
		end
	end

endmodule

/* tb/sv/permutation_combination_counter_tb.sv */
`timescale 1ns / 1ps

module permutation_combination_counter_tb
	import pcc_pkg::*;
();

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             operation = 1'b0;
	logic [VAL_W-1:0] n = '0;
	logic [VAL_W-1:0] k = '0;
	logic             out_valid;
	logic             out_stall = 1'b1;
	logic [RES_W-1:0] result;
	logic             status;
	int               fails;
	int               pending;
	int               taken = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	permutation_combination_counter dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .n(n), .k(k), .out_valid(out_valid), .out_stall(out_stall),
		.result(result), .status(status)
	);

	permutation_combination_counter_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .n(n), .k(k), .out_valid(out_valid), .out_stall(out_stall),
		.result(result), .status(status), .fails(fails), .pending(pending)
	);

	task automatic offer(op_t op, int nn, int kk, bit eager);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		n <= VAL_W'(nn);
		k <= VAL_W'(kk);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	always begin
		int hold;
		@(posedge clk);
		if (arst_n) begin
			hold = (taken == 30) ? 20000 : $urandom_range(0, 18);
			if (taken % 20 > 14)
				hold = 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
		end
	end

	initial begin
		int nn;
		int kk;
		int sel;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		offer(OP_PERM, 0, 0, 0);
		offer(OP_COMB, 0, 0, 0);
		offer(OP_PERM, 511, 0, 0);
		offer(OP_COMB, 511, 1, 0);
		offer(OP_PERM, 511, 511, 0);
		offer(OP_COMB, 511, 511, 0);
		offer(OP_COMB, 511, 255, 0);
		offer(OP_COMB, 5, 6, 0);
		offer(OP_PERM, 0, 1, 0);
		offer(OP_PERM, 0, 511, 0);
		offer(OP_COMB, 510, 511, 0);
		offer(OP_COMB, 509, 2, 0);
		offer(OP_PERM, 509, 4, 0);
		offer(OP_PERM, 20, 20, 0);
		offer(OP_PERM, 30, 30, 0);
		offer(OP_COMB, 64, 32, 0);
		offer(OP_COMB, 67, 33, 0);
		offer(OP_PERM, 10, 3, 0);
		offer(OP_COMB, 10, 3, 0);
		offer(OP_PERM, 256, 5, 0);
		for (int i = 0; i < 100; i++) begin
			sel = $urandom_range(0, 99);
			nn = (sel < 50) ? $urandom_range(0, 40) : $urandom_range(0, 511);
			if (sel < 10)
				kk = $urandom_range(nn + 1, 511);
			else if (sel > 95)
				kk = $urandom_range(0, nn);
			else
				kk = (nn < 12) ? $urandom_range(0, nn) : $urandom_range(0, 12);
			if (i == 60) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			offer(op_t'($urandom_range(0, 1)), nn, kk, (i % 25) > 18);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("permutation_combination_counter_tb: PASS");
		else
			$display("permutation_combination_counter_tb: FAIL");
		$finish;
	end

	initial begin
		#400ms;
		$display("permutation_combination_counter_tb: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
src/pcc_pkg.sv
src/pcc_ram.sv
src/pcc_div.sv
src/permutation_combination_counter.sv
tb/sv/permutation_combination_counter_checker.sv
tb/sv/permutation_combination_counter_tb.sv
